>>> design/iis_pkg.sv
// Package for the integer interval set unit.
// Holds operation codes, fixed field widths and the controller/datapath structs.
// No dependencies.
package iis_pkg;

    // Fixed widths of the channel fields.
    localparam int FIELD_BITS = 32;
    localparam int TOTAL_BITS = 33;
    localparam int COUNT_BITS = 7;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic load;
        logic rd;
        logic proc;
        logic emit2;
        logic fin;
        logic done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run;
        logic scan_end;
        logic pend2;
        logic out_free;
    } t_status;

endpackage

>>> design/iis_if.sv
// Channel interfaces of the integer interval set unit.
// Depends on iis_pkg for the field widths.
interface iis_in_if;
    import iis_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic signed [FIELD_BITS-1:0]  lower_value;
    logic signed [FIELD_BITS-1:0]  upper_value;
    modport source (output valid, kind, lower_value, upper_value, input ready);
    modport sink (input valid, kind, lower_value, upper_value, output ready);
endinterface

interface iis_out_if;
    import iis_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_BITS-1:0]  found_lower;
    logic signed [FIELD_BITS-1:0]  found_upper;
    logic                          point_covered;
    logic [TOTAL_BITS-1:0]         covered_total;
    logic [COUNT_BITS-1:0]         interval_count;
    logic                          capacity_error;
    modport source (output valid, found_lower, found_upper, point_covered,
                    covered_total, interval_count, capacity_error, input ready);
    modport sink (input valid, found_lower, found_upper, point_covered,
                  covered_total, interval_count, capacity_error, output ready);
endinterface

>>> design/integer_interval_set_unit.sv
// Top level of the integer interval set unit.
// Depends on iis_pkg, iis_if, iis_ctrl and iis_datapath.
//
// The unit keeps a sorted table of disjoint half-open intervals in a two-bank
// memory and serves one item at a time. A query, or an insert or erase with a
// non-empty range, scans every stored entry through the memory read port, with
// a read step and a process step per entry; at most one entry per item takes a
// second write step, the one that an erase splits or the one before which an
// insert places its range. After the scan the result beat is registered and the
// unit returns to idle, ready for the next input beat. An insert or erase with
// an empty range, or an unknown kind, skips the scan and goes straight to the
// result. A result beat that is not taken holds the unit, which accepts nothing
// until the output register is free. Insert and erase rebuild the table into
// the other bank and switch banks when the result fits, so a dropped operation
// leaves the table untouched. No clearing pass follows reset.
module integer_interval_set_unit #(
    parameter int MAX_INTERVALS = 64,
    parameter int VALUE_BITS    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iis_in_if.sink    i_in,
    iis_out_if.source o_out
);
    import iis_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    iis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    iis_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

>>> design/iis_ctrl.sv
// Sequencer of the integer interval set unit.
// Depends on iis_pkg for the command and status structs.
module iis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  iis_pkg::t_status i_status,
    output iis_pkg::t_cmd    o_cmd
);
    import iis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PROC, S_EMIT2, S_FIN, S_DONE
    } t_state;

    t_state r_state, n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.run ? S_RD : S_DONE;
                end
            end
            S_RD: begin
                if (i_status.scan_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_PROC;
                end
            end
            S_PROC: begin
                o_cmd.proc = 1'b1;
                n_state    = i_status.pend2 ? S_EMIT2 : S_RD;
            end
            S_EMIT2: begin
                o_cmd.emit2 = 1'b1;
                n_state     = S_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/iis_datapath.sv
// Datapath of the integer interval set unit: ping-pong interval memory,
// scan and merge/split logic, totals and the output register.
// Depends on iis_pkg and the channel interfaces in iis_if.
module iis_datapath #(
    parameter int MAX_INTERVALS = 64,
    parameter int VALUE_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iis_in_if.sink            i_in,
    iis_out_if.source         o_out,
    input  iis_pkg::t_cmd     i_cmd,
    output iis_pkg::t_status  o_status
);
    import iis_pkg::*;

    localparam int IW    = $clog2(MAX_INTERVALS);
    localparam int NW    = $clog2(MAX_INTERVALS + 2);
    localparam int DEPTH = 2 ** (IW + 1);
    localparam int VB    = VALUE_BITS;

    typedef logic signed [VB-1:0] t_val;

    // Two banks of start/end pairs; one holds the table, the other takes the rebuild.
    logic [2*VB-1:0] mem [DEPTH];

    logic            r_cur;
    logic [NW-1:0]   r_idx, r_used, r_n;
    logic [VB:0]     r_sum, r_acc;
    logic [1:0]      r_kind;
    logic            r_mod;
    t_val            r_lo, r_hi, r_flo, r_fhi, r_e2_lo, r_e2_hi;
    logic            r_placed, r_hit;
    logic [2*VB-1:0] r_rdata;

    // Input field conversion: low VALUE_BITS bits of the zero-extended field.
    function automatic t_val to_val(input logic [FIELD_BITS-1:0] raw);
        logic [63:0] w;
        w = {32'b0, raw};
        return w[VB-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] from_val(input t_val v);
        logic [63:0] w;
        w = {{(64-VB){1'b0}}, v};
        return w[FIELD_BITS-1:0];
    endfunction

    t_val in_lo, in_hi;
    assign in_lo = to_val(i_in.lower_value);
    assign in_hi = to_val(i_in.upper_value);

    logic in_range_op;
    assign in_range_op = (i_in.kind == KIND_INSERT || i_in.kind == KIND_ERASE)
                         && (in_lo < in_hi);

    // Entry under examination.
    t_val s, e;
    assign s = r_rdata[2*VB-1:VB];
    assign e = r_rdata[VB-1:0];

    // Per-entry decision: up to two entries written to the new bank.
    logic e1_v, e2_v, n_placed;
    t_val e1_lo, e1_hi, e2_lo, e2_hi, n_lo, n_hi;
    always_comb begin
        e1_v = 1'b0; e2_v = 1'b0;
        e1_lo = s; e1_hi = e; e2_lo = s; e2_hi = e;
        n_lo = r_lo; n_hi = r_hi; n_placed = r_placed;
        if (r_kind == KIND_INSERT) begin
            if (e < r_lo) begin
                e1_v = 1'b1;
            end else if (s > r_hi) begin
                e1_v = 1'b1;
                if (!r_placed) begin
                    e1_lo = r_lo; e1_hi = r_hi;
                    e2_v = 1'b1;
                    n_placed = 1'b1;
                end
            end else begin
                if (s < r_lo) n_lo = s;
                if (e > r_hi) n_hi = e;
            end
        end else if (r_kind == KIND_ERASE) begin
            if (e <= r_lo || s >= r_hi) begin
                e1_v = 1'b1;
            end else if (s < r_lo) begin
                e1_v = 1'b1; e1_hi = r_lo;
                if (r_hi < e) begin
                    e2_v = 1'b1; e2_lo = r_hi;
                end
            end else if (r_hi < e) begin
                e1_v = 1'b1; e1_lo = r_hi;
            end
        end
    end

    // Write port toward the rebuild bank.
    logic wr_en;
    t_val wr_lo, wr_hi;
    always_comb begin
        wr_en = 1'b0; wr_lo = e1_lo; wr_hi = e1_hi;
        if (i_cmd.proc) begin
            wr_en = e1_v;
        end else if (i_cmd.emit2) begin
            wr_en = 1'b1; wr_lo = r_e2_lo; wr_hi = r_e2_hi;
        end else if (i_cmd.fin && r_kind == KIND_INSERT && !r_placed) begin
            wr_en = 1'b1; wr_lo = r_lo; wr_hi = r_hi;
        end
    end

    logic [VB:0] wr_len;
    assign wr_len = {wr_hi[VB-1], wr_hi} - {wr_lo[VB-1], wr_lo};

    // Commit decision at the end of a range operation.
    logic ovf, commit;
    assign ovf    = r_n > NW'(MAX_INTERVALS);
    assign commit = i_cmd.done && r_mod && !ovf;

    logic [NW-1:0] post_used;
    logic [VB:0]   post_sum;
    assign post_used = commit ? r_n : r_used;
    assign post_sum  = commit ? r_acc : r_sum;

    // Status toward the controller.
    assign o_status.run      = in_range_op || (i_in.kind == KIND_QUERY);
    assign o_status.scan_end = (r_idx == r_used);
    assign o_status.pend2    = e2_v;
    assign o_status.out_free = !o_out.valid || o_out.ready;
    assign i_in.ready        = i_cmd.idle;

    // Memory port: registered read, single write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[{r_cur, r_idx[IW-1:0]}];
        end
        if (wr_en && r_n < NW'(MAX_INTERVALS)) begin
            mem[{~r_cur, r_n[IW-1:0]}] <= {wr_lo, wr_hi};
        end
    end

    // Operation registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_in.kind;
            r_lo     <= in_lo;
            r_hi     <= in_hi;
            r_mod    <= in_range_op;
            r_placed <= 1'b0;
            r_hit    <= 1'b0;
            r_flo    <= (i_in.kind == KIND_QUERY) ? in_lo : '0;
            r_fhi    <= (i_in.kind == KIND_QUERY) ? in_lo : '0;
        end
        if (i_cmd.proc) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_placed <= n_placed;
            r_e2_lo  <= e2_lo;
            r_e2_hi  <= e2_hi;
            if (r_kind == KIND_QUERY && !r_hit && s <= r_lo && r_lo < e) begin
                r_hit <= 1'b1;
                r_flo <= s;
                r_fhi <= e;
            end
        end
    end

    // Control state: bank select, counters, totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= 1'b0;
            r_idx  <= '0;
            r_used <= '0;
            r_n    <= '0;
            r_sum  <= '0;
            r_acc  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_n   <= '0;
                r_acc <= '0;
            end
            if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (wr_en) begin
                r_n   <= r_n + 1'b1;
                r_acc <= r_acc + wr_len;
            end
            if (commit) begin
                r_cur  <= ~r_cur;
                r_used <= r_n;
                r_sum  <= r_acc;
            end
        end
    end

    // Output register.
    logic [63:0] sum_w, cnt_w;
    assign sum_w = {{(63-VB){1'b0}}, post_sum};
    assign cnt_w = {{(64-NW){1'b0}}, post_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (i_cmd.done) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_out.found_lower    <= from_val(r_flo);
            o_out.found_upper    <= from_val(r_fhi);
            o_out.point_covered  <= r_hit;
            o_out.covered_total  <= sum_w[TOTAL_BITS-1:0];
            o_out.interval_count <= cnt_w[COUNT_BITS-1:0];
            o_out.capacity_error <= r_mod && ovf;
        end
    end

    // The table never holds more than its capacity.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NW'(MAX_INTERVALS))
        else $error("interval count above capacity");

    // A rebuild produces at most one entry beyond capacity.
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_INTERVALS + 1))
        else $error("rebuild count runaway");

    // A second write of an entry always follows the entry's first step.
    a_emit2_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit2 |-> $past(i_cmd.proc && e2_v))
        else $error("second write without a split");

endmodule

>>> tb/tb_integer_interval_set_unit.sv
// Self-checking testbench for the integer interval set unit.
// Depends on iis_pkg, iis_if and the integer_interval_set_unit RTL.
// Random insert, erase and query beats are checked against a behavioral interval table.
module tb_integer_interval_set_unit;
    import iis_pkg::*;

    localparam int CAP = 64;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // One expected result beat.
    typedef struct packed {
        logic signed [31:0] f_lo;
        logic signed [31:0] f_hi;
        logic               covered;
        logic [32:0]        total;
        logic [6:0]         count;
        logic               err;
    } t_result;

    // Behavioral interval table and the queue of predicted results.
    class interval_scoreboard;
        longint starts[$];
        longint ends[$];
        t_result pending[$];
        int mismatches;

        function automatic void note_item(logic [1:0] kind, logic signed [31:0] lo_v,
                                          logic signed [31:0] hi_v);
            t_result r;
            longint lo, hi, s, e, sum;
            longint ns[$];
            longint ne[$];
            bit placed;
            lo = lo_v;
            hi = hi_v;
            r.f_lo = 0;
            r.f_hi = 0;
            r.covered = 0;
            r.err = 0;
            placed = 0;
            if ((kind == KIND_INSERT || kind == KIND_ERASE) && lo < hi) begin
                for (int i = 0; i < starts.size(); i++) begin
                    s = starts[i];
                    e = ends[i];
                    if (kind == KIND_INSERT) begin
                        if (e < lo) begin
                            ns.push_back(s); ne.push_back(e);
                        end else if (s > hi) begin
                            if (!placed) begin
                                ns.push_back(lo); ne.push_back(hi); placed = 1;
                            end
                            ns.push_back(s); ne.push_back(e);
                        end else begin
                            if (s < lo) lo = s;
                            if (e > hi) hi = e;
                        end
                    end else if (e <= lo || s >= hi) begin
                        ns.push_back(s); ne.push_back(e);
                    end else begin
                        if (s < lo) begin
                            ns.push_back(s); ne.push_back(lo);
                        end
                        if (hi < e) begin
                            ns.push_back(hi); ne.push_back(e);
                        end
                    end
                end
                if (kind == KIND_INSERT && !placed) begin
                    ns.push_back(lo); ne.push_back(hi);
                end
                // A rebuild that does not fit leaves the table as it was.
                if (ns.size() > CAP) r.err = 1;
                else begin
                    starts = ns;
                    ends = ne;
                end
            end else if (kind == KIND_QUERY) begin
                r.f_lo = lo_v;
                r.f_hi = lo_v;
                foreach (starts[i]) begin
                    if (starts[i] <= lo && lo < ends[i]) begin
                        r.f_lo = starts[i];
                        r.f_hi = ends[i];
                        r.covered = 1;
                        break;
                    end
                end
            end
            sum = 0;
            foreach (starts[i]) sum += ends[i] - starts[i];
            r.total = sum;
            r.count = starts.size();
            pending.push_back(r);
        endfunction

        function automatic void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
                return;
            end
            exp = pending.pop_front();
            if (got != exp) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp lo=%0d hi=%0d cov=%0d tot=%0d cnt=%0d err=%0d",
                             exp.f_lo, exp.f_hi, exp.covered, exp.total, exp.count,
                             exp.err);
                    $display("       got lo=%0d hi=%0d cov=%0d tot=%0d cnt=%0d err=%0d",
                             got.f_lo, got.f_hi, got.covered, got.total, got.count,
                             got.err);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    interval_scoreboard sb;

    iis_in_if  in_ch();
    iis_out_if out_ch();

    integer_interval_set_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock generation.
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive one beat into the block, with random idle cycles in front.
    // Valid stays high after the beat; the caller drops it when the stream pauses.
    task automatic send_beat(logic [1:0] kind, logic signed [31:0] lo, logic signed [31:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.kind <= kind;
        in_ch.lower_value <= lo;
        in_ch.upper_value <= hi;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(kind, lo, hi);
    endtask

    // Random values, mostly in a narrow window so that intervals interact.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(400)) - 200;
        endcase
    endfunction

    // Random items for one idling phase.
    task automatic random_phase(int n);
        logic signed [31:0] a, b;
        int w;
        for (int k = 0; k < n; k++) begin
            a = pick_value();
            w = $urandom_range(9);
            b = (w == 0) ? pick_value() : a + $signed($urandom_range(12)) - 1;
            w = $urandom_range(99);
            if (w < 40) send_beat(KIND_INSERT, a, b);
            else if (w < 65) send_beat(KIND_ERASE, a, b);
            else if (w < 98) send_beat(KIND_QUERY, a, b);
            else send_beat(KIND_UNKNOWN, a, b);
        end
    endtask

    // Receiver: random stalls, check on every accepted beat.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.f_lo = out_ch.found_lower;
            got.f_hi = out_ch.found_upper;
            got.covered = out_ch.point_covered;
            got.total = out_ch.covered_total;
            got.count = out_ch.interval_count;
            got.err = out_ch.capacity_error;
            sb.check_result(got);
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Run limit.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    // Main sequence.
    initial begin
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 63;
        in_ch.valid = 0;
        in_ch.kind = KIND_INSERT;
        in_ch.lower_value = 0;
        in_ch.upper_value = 0;
        out_ch.ready = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        // Directed: empty table, extremes, empty ranges, merge, split, unknown kind.
        send_beat(KIND_QUERY, 0, 0);
        send_beat(KIND_INSERT, 32'sh80000000, 32'sh7fffffff);
        send_beat(KIND_QUERY, 32'sh7fffffff, 0);
        send_beat(KIND_QUERY, 32'sh80000000, 0);
        send_beat(KIND_ERASE, -5, 5);
        send_beat(KIND_QUERY, 0, 0);
        send_beat(KIND_INSERT, 5, 5);
        send_beat(KIND_ERASE, 9, 3);
        send_beat(KIND_INSERT, -5, 0);
        send_beat(KIND_INSERT, 0, 5);
        send_beat(KIND_QUERY, 3, 0);
        send_beat(KIND_UNKNOWN, 32'sh7fffffff, 32'sh80000000);
        send_beat(KIND_ERASE, 32'sh80000000, 32'sh7fffffff);
        send_beat(KIND_ERASE, 32'sh7ffffffe, 32'sh7fffffff);
        // Fill the table to capacity, overflow it by insert, then trim and erase entries.
        for (int k = 0; k < CAP; k++) send_beat(KIND_INSERT, k * 4, k * 4 + 2);
        send_beat(KIND_INSERT, 1000, 1001);
        send_beat(KIND_ERASE, 0, 1);
        send_beat(KIND_ERASE, 1, 4);
        send_beat(KIND_ERASE, 32'sh80000000, 32'sh7fffffff);
        // Hold off until every result is back.
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        random_phase(270);
        send_idle_pct = 63;
        recv_idle_pct = 14;
        random_phase(270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(270);
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

>>> sim.f
design/iis_pkg.sv
design/iis_if.sv
design/iis_ctrl.sv
design/iis_datapath.sv
design/integer_interval_set_unit.sv
tb/tb_integer_interval_set_unit.sv
